// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the rotation-between-vectors block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a condition on every clock edge outside reset
`define RBV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that a condition holds in the cycle after a trigger
`define RBV_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== hw/rtl/rbv_pkg.sv =====
// ----------------------------------------------------------------------------
// rbv_pkg
// Types, constants and arithmetic helpers for the rotation-between-vectors block.
// ----------------------------------------------------------------------------
package rbv_pkg;

    localparam int unsigned SQ_STEPS  = 32;
    localparam int unsigned DIV_STEPS = 31;

    localparam logic signed [15:0] Q14_ONE  = 16'sd16384;
    localparam logic signed [15:0] Q14_NEG  = -16'sd16384;
    localparam logic [30:0]        Q30_ONE  = 31'h4000_0000;

    // word passed from the front part to the back part
    typedef struct packed {
        logic signed [32:0] d;
        logic signed [32:0] w0;
        logic signed [32:0] w1;
        logic signed [32:0] w2;
        logic [63:0]        ab;
        logic [63:0]        ww;
        logic               deg;
    } q_word_t;

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
        logic [63:0] rad;
    } sq_unit_t;

    typedef struct packed {
        sq_unit_t           n;
        sq_unit_t           m;
        logic signed [32:0] d;
        logic signed [32:0] w0;
        logic signed [32:0] w1;
        logic signed [32:0] w2;
        logic               deg;
    } sq_stage_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [30:0] qn;
    } dv_unit_t;

    typedef struct packed {
        dv_unit_t [4:0] u;
        logic [31:0]    den_n;
        logic [31:0]    den_m;
        logic [4:0]     neg;
        logic           deg;
    } dv_stage_t;

    function automatic logic [31:0] mag33(input logic signed [32:0] v);
        logic [32:0] m;
        m = v[32] ? 33'(-v) : 33'(v);
        return m[31:0];
    endfunction

    function automatic sq_unit_t sqrt_step(input sq_unit_t x);
        sq_unit_t    y;
        logic [33:0] acc;
        logic [33:0] trial;
        acc   = {x.rem[31:0], x.rad[63:62]};
        trial = {x.root, 2'b01};
        y.rad = {x.rad[61:0], 2'b00};
        if (acc >= trial)
        begin
            y.rem  = acc - trial;
            y.root = {x.root[30:0], 1'b1};
        end
        else
        begin
            y.rem  = acc;
            y.root = {x.root[30:0], 1'b0};
        end
        return y;
    endfunction

    function automatic sq_stage_t sq_stage_step(input sq_stage_t x);
        sq_stage_t y;
        y   = x;
        y.n = sqrt_step(x.n);
        y.m = sqrt_step(x.m);
        return y;
    endfunction

    // numerator (mag * 2^30 + den / 2) split into partial remainder and low bits
    function automatic dv_unit_t div_init(input logic [31:0] mag, input logic [31:0] den);
        dv_unit_t    y;
        logic [63:0] num;
        num   = ({32'b0, mag} << 30) + {33'b0, den[31:1]};
        y.rem = num[62:31];
        y.qn  = num[30:0];
        return y;
    endfunction

    function automatic dv_unit_t div_step(input dv_unit_t x, input logic [31:0] den);
        dv_unit_t    y;
        logic [32:0] acc;
        logic        qb;
        acc = {x.rem, x.qn[30]};
        if (acc >= {1'b0, den})
        begin
            acc = acc - {1'b0, den};
            qb  = 1'b1;
        end
        else
        begin
            qb = 1'b0;
        end
        y.rem = acc[31:0];
        y.qn  = {x.qn[29:0], qb};
        return y;
    endfunction

    function automatic dv_stage_t dv_stage_step(input dv_stage_t x);
        dv_stage_t y;
        y = x;
        for (int j = 0; j < 5; j++)
        begin
            y.u[j] = div_step(x.u[j], (j < 2) ? x.den_n : x.den_m);
        end
        return y;
    endfunction

    // clamp a quotient to one and apply its sign
    function automatic logic signed [31:0] q30_signed(input logic [30:0] q, input logic neg);
        logic [30:0] c;
        c = (q > Q30_ONE) ? Q30_ONE : q;
        return neg ? -$signed({1'b0, c}) : $signed({1'b0, c});
    endfunction

    // round half away from zero, drop 30 fraction bits
    function automatic logic signed [35:0] rsh30(input logic signed [65:0] p);
        logic [65:0] mag;
        logic [35:0] q;
        mag = p[65] ? 66'(-p) : 66'(p);
        q   = 36'((mag + (66'd1 << 29)) >> 30);
        return p[65] ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [15:0] to_q14(input logic signed [35:0] v);
        logic [35:0]        mag;
        logic [20:0]        q;
        logic signed [21:0] r;
        mag = v[35] ? 36'(-v) : 36'(v);
        q   = 21'((mag + 36'd32768) >> 16);
        r   = v[35] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        if (r > 22'sd16384)
        begin
            return Q14_ONE;
        end
        if (r < -22'sd16384)
        begin
            return Q14_NEG;
        end
        return r[15:0];
    endfunction

endpackage

// ===== hw/rtl/rbv_in_if.sv =====
// ----------------------------------------------------------------------------
// rbv_in_if
// Channel carrying one pair of signed 3-vectors per word.
// ----------------------------------------------------------------------------
interface rbv_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [15:0] first_z;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;
    logic signed [15:0] second_z;

    modport source (
        output valid, first_x, first_y, first_z, second_x, second_y, second_z,
        input  ready
    );
    modport sink (
        input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
        output ready
    );
endinterface

// ===== hw/rtl/rbv_out_if.sv =====
// ----------------------------------------------------------------------------
// rbv_out_if
// Channel carrying one Q1.14 rotation matrix and its degenerate flag per word.
// ----------------------------------------------------------------------------
interface rbv_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic               degenerate;

    modport source (
        output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, degenerate,
        input  ready
    );
    modport sink (
        input  valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, degenerate,
        output ready
    );
endinterface

// ===== hw/rtl/rbv_front.sv =====
// ----------------------------------------------------------------------------
// rbv_front
// Accepts vector pairs, forms dot, cross and norm products, flags degenerate pairs.
// ----------------------------------------------------------------------------
module rbv_front
    import rbv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rbv_in_if.sink      vectors,
    output logic        q_valid,
    input  logic        q_ready,
    output q_word_t     q_word
);

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] bx;
        logic signed [15:0] by;
        logic signed [15:0] bz;
    } f1_t;

    typedef struct packed {
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
        logic signed [31:0] yz;
        logic signed [31:0] zy;
        logic signed [31:0] zx;
        logic signed [31:0] xz;
        logic signed [31:0] xy;
        logic signed [31:0] yx;
        logic signed [31:0] aa_x;
        logic signed [31:0] aa_y;
        logic signed [31:0] aa_z;
        logic signed [31:0] bb_x;
        logic signed [31:0] bb_y;
        logic signed [31:0] bb_z;
    } f2_t;

    typedef struct packed {
        logic signed [32:0] d;
        logic signed [32:0] w0;
        logic signed [32:0] w1;
        logic signed [32:0] w2;
        logic [31:0]        a;
        logic [31:0]        b;
    } f3_t;

    typedef struct packed {
        logic signed [32:0] d;
        logic signed [32:0] w0;
        logic signed [32:0] w1;
        logic signed [32:0] w2;
        logic [63:0]        ab;
        logic [63:0]        s0;
        logic [63:0]        s1;
        logic [63:0]        s2;
    } f4_t;

    logic [4:0] vld_reg;
    logic       adv;
    f1_t        f1_reg;
    f2_t        f2_reg;
    f3_t        f3_reg;
    f4_t        f4_reg;
    q_word_t    f5_reg;
    logic [31:0] m0;
    logic [31:0] m1;
    logic [31:0] m2;
    logic [63:0] ww;

    assign adv           = !vld_reg[4] || q_ready;
    assign vectors.ready = adv;
    assign q_valid       = vld_reg[4];
    assign q_word        = f5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[3:0], vectors.valid};
        end
    end

    assign m0 = mag33(f3_reg.w0);
    assign m1 = mag33(f3_reg.w1);
    assign m2 = mag33(f3_reg.w2);
    assign ww = f4_reg.s0 + f4_reg.s1 + f4_reg.s2;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_reg.ax <= vectors.first_x;
            f1_reg.ay <= vectors.first_y;
            f1_reg.az <= vectors.first_z;
            f1_reg.bx <= vectors.second_x;
            f1_reg.by <= vectors.second_y;
            f1_reg.bz <= vectors.second_z;

            f2_reg.dx   <= 32'(f1_reg.ax) * 32'(f1_reg.bx);
            f2_reg.dy   <= 32'(f1_reg.ay) * 32'(f1_reg.by);
            f2_reg.dz   <= 32'(f1_reg.az) * 32'(f1_reg.bz);
            f2_reg.yz   <= 32'(f1_reg.ay) * 32'(f1_reg.bz);
            f2_reg.zy   <= 32'(f1_reg.az) * 32'(f1_reg.by);
            f2_reg.zx   <= 32'(f1_reg.az) * 32'(f1_reg.bx);
            f2_reg.xz   <= 32'(f1_reg.ax) * 32'(f1_reg.bz);
            f2_reg.xy   <= 32'(f1_reg.ax) * 32'(f1_reg.by);
            f2_reg.yx   <= 32'(f1_reg.ay) * 32'(f1_reg.bx);
            f2_reg.aa_x <= 32'(f1_reg.ax) * 32'(f1_reg.ax);
            f2_reg.aa_y <= 32'(f1_reg.ay) * 32'(f1_reg.ay);
            f2_reg.aa_z <= 32'(f1_reg.az) * 32'(f1_reg.az);
            f2_reg.bb_x <= 32'(f1_reg.bx) * 32'(f1_reg.bx);
            f2_reg.bb_y <= 32'(f1_reg.by) * 32'(f1_reg.by);
            f2_reg.bb_z <= 32'(f1_reg.bz) * 32'(f1_reg.bz);

            f3_reg.d  <= 33'(f2_reg.dx) + 33'(f2_reg.dy) + 33'(f2_reg.dz);
            f3_reg.w0 <= 33'(f2_reg.yz) - 33'(f2_reg.zy);
            f3_reg.w1 <= 33'(f2_reg.zx) - 33'(f2_reg.xz);
            f3_reg.w2 <= 33'(f2_reg.xy) - 33'(f2_reg.yx);
            f3_reg.a  <= unsigned'(f2_reg.aa_x) + unsigned'(f2_reg.aa_y)
                         + unsigned'(f2_reg.aa_z);
            f3_reg.b  <= unsigned'(f2_reg.bb_x) + unsigned'(f2_reg.bb_y)
                         + unsigned'(f2_reg.bb_z);

            f4_reg.d  <= f3_reg.d;
            f4_reg.w0 <= f3_reg.w0;
            f4_reg.w1 <= f3_reg.w1;
            f4_reg.w2 <= f3_reg.w2;
            f4_reg.ab <= {32'b0, f3_reg.a} * {32'b0, f3_reg.b};
            f4_reg.s0 <= {32'b0, m0} * {32'b0, m0};
            f4_reg.s1 <= {32'b0, m1} * {32'b0, m1};
            f4_reg.s2 <= {32'b0, m2} * {32'b0, m2};

            f5_reg.d   <= f4_reg.d;
            f5_reg.w0  <= f4_reg.w0;
            f5_reg.w1  <= f4_reg.w1;
            f5_reg.w2  <= f4_reg.w2;
            f5_reg.ab  <= f4_reg.ab;
            f5_reg.ww  <= ww;
            f5_reg.deg <= (ww == 64'd0);
        end
    end

endmodule

// ===== hw/rtl/rbv_fifo.sv =====
// ----------------------------------------------------------------------------
// rbv_fifo
// Short queue of classified words between the front and back parts.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rbv_fifo
    import rbv_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_valid,
    output logic    wr_ready,
    input  q_word_t wr_word,
    output logic    rd_valid,
    input  logic    rd_ready,
    output q_word_t rd_word
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    q_word_t          mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    cnt_reg;
    logic             push;
    logic             pop;

    assign wr_ready = (cnt_reg != CW'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_word  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_word;
        end
    end

    `RBV_ASSERT(a_cnt_bound, cnt_reg <= CW'(DEPTH), "queue count beyond depth")
    `RBV_ASSERT_NEXT(a_cnt_push, push && !pop, cnt_reg == $past(cnt_reg) + CW'(1), "push lost")
    `RBV_ASSERT_NEXT(a_cnt_pop, pop && !push, cnt_reg == $past(cnt_reg) - CW'(1), "pop lost")

endmodule

// ===== hw/rtl/rbv_back.sv =====
// ----------------------------------------------------------------------------
// rbv_back
// Square roots, divisions and products that build the rotation matrix.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rbv_back
    import rbv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_ready,
    input  q_word_t     q_word,
    rbv_out_if.source   rotation
);

    localparam int unsigned STAGES = SQ_STEPS + DIV_STEPS + 7;
    localparam int unsigned LAST   = STAGES - 1;

    typedef struct packed {
        logic signed [31:0] c;
        logic signed [31:0] s;
        logic signed [31:0] k0;
        logic signed [31:0] k1;
        logic signed [31:0] k2;
        logic signed [32:0] t;
        logic               deg;
    } rs_t;

    typedef struct packed {
        logic signed [31:0] c;
        logic signed [31:0] s;
        logic signed [31:0] k0;
        logic signed [31:0] k1;
        logic signed [31:0] k2;
        logic signed [65:0] p0;
        logic signed [65:0] p1;
        logic signed [65:0] p2;
        logic               deg;
    } m1_t;

    typedef struct packed {
        logic signed [31:0] c;
        logic signed [31:0] s;
        logic signed [31:0] k0;
        logic signed [31:0] k1;
        logic signed [31:0] k2;
        logic signed [32:0] tk0;
        logic signed [32:0] tk1;
        logic signed [32:0] tk2;
        logic               deg;
    } m2_t;

    typedef struct packed {
        logic signed [31:0] c;
        logic signed [65:0] p00;
        logic signed [65:0] p11;
        logic signed [65:0] p22;
        logic signed [65:0] p01;
        logic signed [65:0] p02;
        logic signed [65:0] p12;
        logic signed [65:0] ps0;
        logic signed [65:0] ps1;
        logic signed [65:0] ps2;
        logic               deg;
    } m3_t;

    typedef struct packed {
        logic signed [31:0] c;
        logic signed [32:0] q00;
        logic signed [32:0] q11;
        logic signed [32:0] q22;
        logic signed [32:0] q01;
        logic signed [32:0] q02;
        logic signed [32:0] q12;
        logic signed [32:0] qs0;
        logic signed [32:0] qs1;
        logic signed [32:0] qs2;
        logic               deg;
    } m4_t;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
        logic               deg;
    } out_t;

    logic [LAST:0] vld_reg;
    logic          adv;
    sq_stage_t     sq_in;
    sq_stage_t     sq_reg [SQ_STEPS];
    dv_stage_t     dv_in;
    dv_stage_t     dv_reg [DIV_STEPS + 1];
    rs_t           rs_in;
    rs_t           rs_reg;
    m1_t           m1_reg;
    m2_t           m2_reg;
    m3_t           m3_reg;
    m4_t           m4_reg;
    out_t          out_in;
    out_t          out_reg;
    sq_stage_t     sq_last;
    dv_stage_t     dv_last;

    assign adv     = !vld_reg[LAST] || rotation.ready;
    assign q_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAST-1:0], q_valid};
        end
    end

    always_comb
    begin
        sq_in.n.rem  = '0;
        sq_in.n.root = '0;
        sq_in.n.rad  = q_word.ab;
        sq_in.m.rem  = '0;
        sq_in.m.root = '0;
        sq_in.m.rad  = q_word.ww;
        sq_in.d      = q_word.d;
        sq_in.w0     = q_word.w0;
        sq_in.w1     = q_word.w1;
        sq_in.w2     = q_word.w2;
        sq_in.deg    = q_word.deg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg[0] <= sq_stage_step(sq_in);
        end
    end

    for (genvar i = 1; i < SQ_STEPS; i++)
    begin : g_sq
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_reg[i] <= sq_stage_step(sq_reg[i-1]);
            end
        end
    end

    assign sq_last = sq_reg[SQ_STEPS-1];

    always_comb
    begin
        dv_in.den_n = sq_last.n.root;
        dv_in.den_m = sq_last.m.root;
        dv_in.u[0]  = div_init(mag33(sq_last.d), sq_last.n.root);
        dv_in.u[1]  = div_init(sq_last.m.root, sq_last.n.root);
        dv_in.u[2]  = div_init(mag33(sq_last.w0), sq_last.m.root);
        dv_in.u[3]  = div_init(mag33(sq_last.w1), sq_last.m.root);
        dv_in.u[4]  = div_init(mag33(sq_last.w2), sq_last.m.root);
        dv_in.neg   = {sq_last.w2[32], sq_last.w1[32], sq_last.w0[32], 1'b0, sq_last.d[32]};
        dv_in.deg   = sq_last.deg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_reg[0] <= dv_in;
        end
    end

    for (genvar j = 1; j <= DIV_STEPS; j++)
    begin : g_dv
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_reg[j] <= dv_stage_step(dv_reg[j-1]);
            end
        end
    end

    assign dv_last = dv_reg[DIV_STEPS];

    always_comb
    begin
        rs_in.c   = q30_signed(dv_last.u[0].qn, dv_last.neg[0]);
        rs_in.s   = q30_signed(dv_last.u[1].qn, dv_last.neg[1]);
        rs_in.k0  = q30_signed(dv_last.u[2].qn, dv_last.neg[2]);
        rs_in.k1  = q30_signed(dv_last.u[3].qn, dv_last.neg[3]);
        rs_in.k2  = q30_signed(dv_last.u[4].qn, dv_last.neg[4]);
        rs_in.t   = $signed({3'b001, 30'b0}) - 33'(rs_in.c);
        rs_in.deg = dv_last.deg;
    end

    always_comb
    begin
        out_in.m00 = to_q14(36'(m4_reg.c) + 36'(m4_reg.q00));
        out_in.m11 = to_q14(36'(m4_reg.c) + 36'(m4_reg.q11));
        out_in.m22 = to_q14(36'(m4_reg.c) + 36'(m4_reg.q22));
        out_in.m01 = to_q14(36'(m4_reg.q01) - 36'(m4_reg.qs2));
        out_in.m10 = to_q14(36'(m4_reg.q01) + 36'(m4_reg.qs2));
        out_in.m02 = to_q14(36'(m4_reg.q02) + 36'(m4_reg.qs1));
        out_in.m20 = to_q14(36'(m4_reg.q02) - 36'(m4_reg.qs1));
        out_in.m12 = to_q14(36'(m4_reg.q12) - 36'(m4_reg.qs0));
        out_in.m21 = to_q14(36'(m4_reg.q12) + 36'(m4_reg.qs0));
        out_in.deg = m4_reg.deg;
        if (m4_reg.deg)
        begin
            out_in.m00 = Q14_ONE;
            out_in.m11 = Q14_ONE;
            out_in.m22 = Q14_ONE;
            out_in.m01 = '0;
            out_in.m02 = '0;
            out_in.m10 = '0;
            out_in.m12 = '0;
            out_in.m20 = '0;
            out_in.m21 = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rs_reg <= rs_in;

            m1_reg.c   <= rs_reg.c;
            m1_reg.s   <= rs_reg.s;
            m1_reg.k0  <= rs_reg.k0;
            m1_reg.k1  <= rs_reg.k1;
            m1_reg.k2  <= rs_reg.k2;
            m1_reg.p0  <= 66'(rs_reg.t) * 66'(rs_reg.k0);
            m1_reg.p1  <= 66'(rs_reg.t) * 66'(rs_reg.k1);
            m1_reg.p2  <= 66'(rs_reg.t) * 66'(rs_reg.k2);
            m1_reg.deg <= rs_reg.deg;

            m2_reg.c   <= m1_reg.c;
            m2_reg.s   <= m1_reg.s;
            m2_reg.k0  <= m1_reg.k0;
            m2_reg.k1  <= m1_reg.k1;
            m2_reg.k2  <= m1_reg.k2;
            m2_reg.tk0 <= 33'(rsh30(m1_reg.p0));
            m2_reg.tk1 <= 33'(rsh30(m1_reg.p1));
            m2_reg.tk2 <= 33'(rsh30(m1_reg.p2));
            m2_reg.deg <= m1_reg.deg;

            m3_reg.c   <= m2_reg.c;
            m3_reg.p00 <= 66'(m2_reg.tk0) * 66'(m2_reg.k0);
            m3_reg.p11 <= 66'(m2_reg.tk1) * 66'(m2_reg.k1);
            m3_reg.p22 <= 66'(m2_reg.tk2) * 66'(m2_reg.k2);
            m3_reg.p01 <= 66'(m2_reg.tk0) * 66'(m2_reg.k1);
            m3_reg.p02 <= 66'(m2_reg.tk0) * 66'(m2_reg.k2);
            m3_reg.p12 <= 66'(m2_reg.tk1) * 66'(m2_reg.k2);
            m3_reg.ps0 <= 66'(m2_reg.s) * 66'(m2_reg.k0);
            m3_reg.ps1 <= 66'(m2_reg.s) * 66'(m2_reg.k1);
            m3_reg.ps2 <= 66'(m2_reg.s) * 66'(m2_reg.k2);
            m3_reg.deg <= m2_reg.deg;

            m4_reg.c   <= m3_reg.c;
            m4_reg.q00 <= 33'(rsh30(m3_reg.p00));
            m4_reg.q11 <= 33'(rsh30(m3_reg.p11));
            m4_reg.q22 <= 33'(rsh30(m3_reg.p22));
            m4_reg.q01 <= 33'(rsh30(m3_reg.p01));
            m4_reg.q02 <= 33'(rsh30(m3_reg.p02));
            m4_reg.q12 <= 33'(rsh30(m3_reg.p12));
            m4_reg.qs0 <= 33'(rsh30(m3_reg.ps0));
            m4_reg.qs1 <= 33'(rsh30(m3_reg.ps1));
            m4_reg.qs2 <= 33'(rsh30(m3_reg.ps2));
            m4_reg.deg <= m3_reg.deg;

            out_reg <= out_in;
        end
    end

    assign rotation.valid      = vld_reg[LAST];
    assign rotation.m00        = out_reg.m00;
    assign rotation.m01        = out_reg.m01;
    assign rotation.m02        = out_reg.m02;
    assign rotation.m10        = out_reg.m10;
    assign rotation.m11        = out_reg.m11;
    assign rotation.m12        = out_reg.m12;
    assign rotation.m20        = out_reg.m20;
    assign rotation.m21        = out_reg.m21;
    assign rotation.m22        = out_reg.m22;
    assign rotation.degenerate = out_reg.deg;

    `RBV_ASSERT_NEXT(a_out_fill, adv && vld_reg[LAST-1], rotation.valid, "result lost")
    `RBV_ASSERT_NEXT(a_out_hold, !adv, $stable(vld_reg), "pipeline moved under stall")
    `RBV_ASSERT_NEXT(a_pop_enter, q_valid && adv, vld_reg[0], "popped word not in pipeline")

endmodule

// ===== hw/rtl/rotation_between_two_vectors_top.sv =====
// ----------------------------------------------------------------------------
// rotation_between_two_vectors_top
// Rotation matrix (Q1.14) turning one signed 3-vector onto another.
// ----------------------------------------------------------------------------
//  channel    modport   word
//  vectors    sink      first_x/y/z, second_x/y/z (signed 16)
//  rotation   source    m00..m22 (signed Q1.14), degenerate
//
//  One word per cycle sustained while rotation is ready; path: 5 front
//  stages, queue, 32 square-root steps, 32 division stages, 6 product stages.
//  Latency is set by the bit-per-stage square roots and dividers.
//  rst_n clears all valid state at once; no clearing pass.
//  A stalled rotation port freezes the back pipeline; the front keeps
//  accepting until the queue is full and a word waits in its last stage.
// ----------------------------------------------------------------------------
module rotation_between_two_vectors_top
    import rbv_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    rbv_in_if.sink    vectors,
    rbv_out_if.source rotation
);

    logic    fq_valid;
    logic    fq_ready;
    q_word_t fq_word;
    logic    qb_valid;
    logic    qb_ready;
    q_word_t qb_word;

    rbv_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .vectors (vectors),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_word  (fq_word)
    );

    rbv_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_word  (fq_word),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_word  (qb_word)
    );

    rbv_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (qb_valid),
        .q_ready  (qb_ready),
        .q_word   (qb_word),
        .rotation (rotation)
    );

endmodule

// ===== verif/rotation_between_two_vectors_top_tb.sv =====
// ----------------------------------------------------------------------------
// rotation_between_two_vectors_top_tb
// Drives signed vector pairs into the rotation block and checks every
// returned Q1.14 matrix and degenerate flag against an exact-integer
// Rodrigues predictor, under random idling on both channels.
// ----------------------------------------------------------------------------
module rotation_between_two_vectors_top_tb;
    import rbv_pkg::*;

    typedef struct {
        logic signed [15:0] ax, ay, az, bx, by, bz;
    } pair_t;

    typedef struct {
        logic signed [15:0] m [9];
        logic               deg;
    } rot_t;

    typedef struct {
        pair_t p;
        bit    known;
        rot_t  r;
    } row_t;

    localparam longint Q30 = 64'sd1 << 30;
    localparam int LIMIT = 400000;

    logic clk;
    logic rst_n;
    rbv_in_if  vectors ();
    rbv_out_if rotation ();

    rotation_between_two_vectors_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .vectors  (vectors),
        .rotation (rotation)
    );

    rot_t  expected_q [$];
    int    errors;
    int    cycles;
    int    src_idle;
    int    snk_idle;
    bit    done;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint unsigned isqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint round_div(input longint num, input longint unsigned den);
        longint unsigned mag;
        longint unsigned q;
        mag = (num < 0) ? longint'(-num) : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint round_shift(input longint num, input int sh);
        longint unsigned mag;
        longint unsigned q;
        mag = (num < 0) ? longint'(-num) : num;
        q = (mag + (64'd1 << (sh - 1))) >> sh;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint qm(input longint u, input longint v);
        return round_shift(u * v, 30);
    endfunction

    function automatic rot_t identity_rot();
        rot_t r;
        for (int i = 0; i < 9; i++)
            r.m[i] = (i % 4 == 0) ? Q14_ONE : 16'sd0;
        r.deg = 1'b1;
        return r;
    endfunction

    function automatic rot_t predict_rotation(input pair_t p);
        longint ax, ay, az, bx, by, bz, d, c, s, t;
        longint w [3];
        longint k [3];
        longint tk [3];
        longint e [9];
        longint unsigned aa, bb, ww, n, mm;
        rot_t r;
        ax = p.ax; ay = p.ay; az = p.az;
        bx = p.bx; by = p.by; bz = p.bz;
        d = ax * bx + ay * by + az * bz;
        w[0] = ay * bz - az * by;
        w[1] = az * bx - ax * bz;
        w[2] = ax * by - ay * bx;
        aa = ax * ax + ay * ay + az * az;
        bb = bx * bx + by * by + bz * bz;
        ww = longint'(w[0] * w[0]) + longint'(w[1] * w[1]) + longint'(w[2] * w[2]);
        if (ww == 0)
            return identity_rot();
        n = isqrt(aa * bb);
        mm = isqrt(ww);
        c = clip(round_div(d * Q30, n), -Q30, Q30);
        s = clip(round_div(longint'(mm) * Q30, n), 0, Q30);
        t = Q30 - c;
        for (int i = 0; i < 3; i++)
        begin
            k[i] = clip(round_div(w[i] * Q30, mm), -Q30, Q30);
            tk[i] = qm(t, k[i]);
        end
        e[0] = c + qm(tk[0], k[0]);
        e[4] = c + qm(tk[1], k[1]);
        e[8] = c + qm(tk[2], k[2]);
        e[1] = qm(tk[0], k[1]) - qm(s, k[2]);
        e[3] = qm(tk[0], k[1]) + qm(s, k[2]);
        e[2] = qm(tk[0], k[2]) + qm(s, k[1]);
        e[6] = qm(tk[0], k[2]) - qm(s, k[1]);
        e[5] = qm(tk[1], k[2]) - qm(s, k[0]);
        e[7] = qm(tk[1], k[2]) + qm(s, k[0]);
        for (int i = 0; i < 9; i++)
            r.m[i] = 16'(clip(round_shift(e[i], 16), -16384, 16384));
        r.deg = 1'b0;
        return r;
    endfunction

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($signed($urandom_range(0, 8)) - 4);
            3: return 16'($signed($urandom_range(0, 512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic pair_t rand_pair();
        pair_t p;
        int    f;
        p.ax = rand_comp(); p.ay = rand_comp(); p.az = rand_comp();
        p.bx = rand_comp(); p.by = rand_comp(); p.bz = rand_comp();
        case ($urandom_range(0, 19))
            0:
            begin
                p.bx = p.ax; p.by = p.ay; p.bz = p.az;
            end
            1:
            begin
                p.bx = -p.ax >>> 1; p.by = -p.ay >>> 1; p.bz = -p.az >>> 1;
            end
            2:
            begin
                p.ax = '0; p.ay = '0; p.az = '0;
            end
            3:
            begin
                f = $urandom_range(1, 3);
                p.ax = 16'($signed($urandom_range(0, 2000)) - 1000);
                p.ay = 16'($signed($urandom_range(0, 2000)) - 1000);
                p.az = 16'($signed($urandom_range(0, 2000)) - 1000);
                p.bx = 16'(p.ax * f); p.by = 16'(p.ay * f); p.bz = 16'(p.az * f);
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic send_pair(input pair_t p);
        while ($urandom_range(0, 99) < src_idle)
        begin
            vectors.valid <= 1'b0;
            @(negedge clk);
        end
        vectors.valid    <= 1'b1;
        vectors.first_x  <= p.ax;
        vectors.first_y  <= p.ay;
        vectors.first_z  <= p.az;
        vectors.second_x <= p.bx;
        vectors.second_y <= p.by;
        vectors.second_z <= p.bz;
        @(posedge clk);
        while (!vectors.ready)
            @(posedge clk);
        expected_q.push_back(predict_rotation(p));
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic signed [15:0] exp_v,
                               input logic signed [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s expected %0d actual %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        rot_t  e;
        rot_t  a;
        if (rst_n && rotation.valid && rotation.ready)
        begin
            a.m = '{rotation.m00, rotation.m01, rotation.m02, rotation.m10, rotation.m11,
                    rotation.m12, rotation.m20, rotation.m21, rotation.m22};
            a.deg = rotation.degenerate;
            if (expected_q.size() == 0)
            begin
                $error("rotation word with no expectation");
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                for (int i = 0; i < 9; i++)
                    check_field($sformatf("m%0d%0d", i / 3, i % 3), e.m[i], a.m[i]);
                check_field("degenerate", 16'(e.deg), 16'(a.deg));
            end
        end
    end

    always @(negedge clk)
        rotation.ready <= ($urandom_range(0, 99) >= snk_idle);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT && !done)
        begin
            $display("rotation_between_two_vectors_top regression: fail");
            $finish;
        end
    end

    row_t dir_rows [$];

    task automatic add_row(input int ax, ay, az, bx, by, bz, input bit known);
        row_t w;
        w.p = '{16'(ax), 16'(ay), 16'(az), 16'(bx), 16'(by), 16'(bz)};
        w.known = known;
        w.r = identity_rot();
        dir_rows.push_back(w);
    endtask

    initial
    begin
        int   tail;
        rot_t chk;
        errors = 0; cycles = 0; done = 0;
        src_idle = 9; snk_idle = 60;
        rst_n = 1'b0;
        vectors.valid = 1'b0;
        vectors.first_x = 0; vectors.first_y = 0; vectors.first_z = 0;
        vectors.second_x = 0; vectors.second_y = 0; vectors.second_z = 0;
        rotation.ready = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // degenerate rows: zero, parallel, antiparallel
        add_row(0, 0, 0, 0, 0, 0, 1);
        add_row(0, 0, 0, 5, -3, 7, 1);
        add_row(100, 200, -300, 0, 0, 0, 1);
        add_row(1, 2, 3, 2, 4, 6, 1);
        add_row(-32768, -32768, -32768, 32767, 32767, 32767, 0);
        add_row(-32768, 0, 0, 32767, 0, 0, 1);
        add_row(1, 0, 0, -1, 0, 0, 1);
        add_row(-32768, -32768, -32768, -32768, -32768, -32768, 1);
        add_row(32767, 32767, 32767, 32767, 32767, 32767, 1);
        // general rows, predictor-checked
        add_row(1, 0, 0, 0, 1, 0, 0);
        add_row(0, 1, 0, 0, 0, 1, 0);
        add_row(0, 0, 1, 1, 0, 0, 0);
        add_row(32767, 0, 0, 0, -32768, 0, 0);
        add_row(-32768, 32767, -32768, 32767, -32768, 32767, 0);
        add_row(-32768, -32768, 0, 32767, -32768, 0, 0);
        add_row(32767, 1, 0, -32768, 0, 1, 0);
        add_row(1, 1, 0, -1, 0, 0, 0);
        add_row(1000, 1, 0, -1000, 0, 0, 0);
        add_row(3, -7, 11, -13, 17, -19, 0);
        add_row(-1, -1, -1, 1, -1, 1, 0);
        add_row(32767, 32767, -32768, 1, 0, 0, 0);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].known)
            begin
                chk = predict_rotation(dir_rows[i].p);
                if (chk.m != dir_rows[i].r.m || chk.deg != dir_rows[i].r.deg)
                begin
                    $error("row %0d identity table mismatch", i);
                    errors++;
                end
            end
            send_pair(dir_rows[i].p);
        end

        for (int i = 0; i < 900; i++)
        begin
            if (i == 300) begin src_idle = 60; snk_idle = 9; end
            if (i == 600) begin src_idle = 0; snk_idle = 0; end
            send_pair(rand_pair());
        end
        vectors.valid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        tail = 0;
        while (tail < 200)
        begin
            @(posedge clk);
            tail++;
        end
        done = 1;
        if (errors == 0)
            $display("rotation_between_two_vectors_top regression: pass");
        else
            $display("rotation_between_two_vectors_top regression: fail");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/rbv_pkg.sv
hw/rtl/rbv_in_if.sv
hw/rtl/rbv_out_if.sv
hw/rtl/rbv_front.sv
hw/rtl/rbv_fifo.sv
hw/rtl/rbv_back.sv
hw/rtl/rotation_between_two_vectors_top.sv
verif/rotation_between_two_vectors_top_tb.sv
